### src/eq3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-band equalizer package
// Payload types, register indexes, reset values and fixed-point widths.
// ----------------------------------------------------------------------------
package eq3_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int CHANNELS_MAX     = 16;

    localparam int CH_FIELD_W = 3;
    localparam int SAMPLE_W   = 24;
    localparam int STATE_W    = 32;
    localparam int COEF_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int STAGES     = 4;
    localparam int HIST       = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

    localparam logic [COEF_W-1:0] LOW_COEF_RESET  = 17'd6861;
    localparam logic [COEF_W-1:0] HIGH_COEF_RESET = 17'd42127;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd4096;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]      channel_in;
        logic signed [SAMPLE_W-1:0] sample_in;
    } eq_in_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]      channel_out;
        logic signed [SAMPLE_W-1:0] sample_out;
    } eq_out_t;

endpackage

### src/three_band_audio_equalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-band audio equalizer
// Per-channel four-pole low and high cascades, gain-weighted band sum,
// one shared multiplier under a step sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request on in_data (channel, Q1.23 sample) is taken when in_valid and
//   in_ready are high. The equalized sample leaves on out_data under
//   out_valid/out_ready, one result per request, in order.
//   in_ready is high only while the sequencer is idle. A request passes from
//   acceptance to out_valid through the memory read at the accepting edge,
//   the load step, twelve steps of the shared 33x18 multiplier (eight
//   interleaved pole updates, three gain products) and the finish step. A
//   channel number at or above CHANNELS bypasses the filters and goes from
//   acceptance straight to the finish step. The next request is taken the
//   cycle after the result is loaded into the output register, so requests
//   are never overlapped.
//   If the receiver stalls, the finished result waits in the finish step
//   until the output register frees up.
//   Reset clears all channel state through one valid bit per channel and
//   restores the register defaults; configuration writes on cfg_we take
//   effect at once and must occur only while idle.
// ----------------------------------------------------------------------------
module three_band_audio_equalizer #(
    parameter int CHANNELS = eq3_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  eq3_pkg::eq_in_t                 in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output eq3_pkg::eq_out_t                out_data,
    input  logic                            cfg_we,
    input  logic [eq3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eq3_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import eq3_pkg::*;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_EXT_W   = 5;
    localparam int ROW_W      = STAGES * STATE_W;
    localparam int HIST_ROW_W = HIST * SAMPLE_W;
    localparam int UNITS      = 2 * STAGES;
    localparam int MUL_A_W    = STATE_W + 1;
    localparam int MUL_B_W    = COEF_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int RND_W      = PROD_W - 16;
    localparam int SUM_W      = STATE_W + 4;
    localparam int OUT_RND_W  = ACC_W - 17;

    localparam logic [3:0] STEP_LAST_UNIT = 4'd7;
    localparam logic [3:0] STEP_LOW_GAIN  = 4'd8;
    localparam logic [3:0] STEP_MID_GAIN  = 4'd9;
    localparam logic [3:0] STEP_HIGH_GAIN = 4'd10;
    localparam logic [3:0] STEP_LAST      = 4'd11;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_FINISH} state_t;

    state_t                      state_reg;
    logic [3:0]                  step_reg;
    logic                        pass_reg;
    logic [CH_W-1:0]             idx_reg;
    logic                        row_valid_reg;
    logic [CHANNELS-1:0]         chan_valid_reg;
    logic                        out_valid_reg;
    eq_out_t                     out_data_reg;

    logic [COEF_W-1:0]           low_coef_reg;
    logic [COEF_W-1:0]           high_coef_reg;
    logic [GAIN_W-1:0]           low_gain_reg;
    logic [GAIN_W-1:0]           mid_gain_reg;
    logic [GAIN_W-1:0]           high_gain_reg;

    logic [CH_FIELD_W-1:0]       ch_reg;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic [ROW_W-1:0]            low_rd_reg;
    logic [ROW_W-1:0]            high_rd_reg;
    logic [HIST_ROW_W-1:0]       hist_rd_reg;
    logic signed [STATE_W-1:0]   st_reg [UNITS];
    logic signed [STATE_W-1:0]   s_hold_reg;
    logic signed [STATE_W-1:0]   x_low_reg;
    logic signed [STATE_W-1:0]   x_high_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;

    logic [ROW_W-1:0]            low_mem  [CHANNELS];
    logic [ROW_W-1:0]            high_mem [CHANNELS];
    logic [HIST_ROW_W-1:0]       hist_mem [CHANNELS];

    logic [CH_EXT_W-1:0]         in_ch_ext;
    logic                        in_range;
    logic [CH_W-1:0]             in_idx;
    logic                        in_accept;
    logic                        out_free;
    logic                        wb_en;
    logic                        rd_en;

    logic [HIST_ROW_W-1:0]       hist_row;
    logic signed [SAMPLE_W-1:0]  dly;
    logic signed [STATE_W-1:0]   xs;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [RND_W-1:0]     rnd;
    logic signed [SUM_W-1:0]     sum;
    logic signed [STATE_W-1:0]   sat_sum;
    logic signed [ACC_W-1:0]     acc_rnd;
    logic signed [OUT_RND_W-1:0] out_rnd;
    logic signed [SAMPLE_W-1:0]  sat_out;
    logic [ROW_W-1:0]            low_wr;
    logic [ROW_W-1:0]            high_wr;
    logic [HIST_ROW_W-1:0]       hist_wr;

    assign in_ch_ext = {2'b00, in_data.channel_in};
    assign in_range  = in_ch_ext < CH_EXT_W'(CHANNELS);
    assign in_idx    = in_ch_ext[CH_W-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign rd_en     = in_accept && in_range;
    assign out_free  = !out_valid_reg || out_ready;
    assign wb_en     = (state_reg == ST_FINISH) && !pass_reg && out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hist_row = row_valid_reg ? hist_rd_reg : '0;
    assign dly      = $signed(hist_row[HIST_ROW_W-1 -: SAMPLE_W]);
    assign xs       = {{3{sample_reg[SAMPLE_W-1]}}, sample_reg, 5'b0};

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg) inside
            [4'd0:STEP_LAST_UNIT]:
            begin
                if (step_reg[0])
                begin
                    mul_a = {x_high_reg[STATE_W-1], x_high_reg}
                          - {st_reg[0][STATE_W-1], st_reg[0]};
                    mul_b = {1'b0, high_coef_reg};
                end
                else
                begin
                    mul_a = {x_low_reg[STATE_W-1], x_low_reg}
                          - {st_reg[0][STATE_W-1], st_reg[0]};
                    mul_b = {1'b0, low_coef_reg};
                end
            end
            STEP_LOW_GAIN:
            begin
                mul_a = {x_low_reg[STATE_W-1], x_low_reg};
                mul_b = {2'b00, low_gain_reg};
            end
            STEP_MID_GAIN:
            begin
                mul_a = {x_high_reg[STATE_W-1], x_high_reg}
                      - {x_low_reg[STATE_W-1], x_low_reg};
                mul_b = {2'b00, mid_gain_reg};
            end
            STEP_HIGH_GAIN:
            begin
                mul_a = {{4{dly[SAMPLE_W-1]}}, dly, 5'b0}
                      - {x_high_reg[STATE_W-1], x_high_reg};
                mul_b = {2'b00, high_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Pole update: round, add, saturate
    assign prod_rnd = prod_reg + PROD_W'(32768);
    assign rnd      = prod_rnd[PROD_W-1:16];
    assign sum      = {{(SUM_W-STATE_W){s_hold_reg[STATE_W-1]}}, s_hold_reg}
                    + {{(SUM_W-RND_W){rnd[RND_W-1]}}, rnd};

    always_comb
    begin
        if ((&sum[SUM_W-1:STATE_W-1]) || !(|sum[SUM_W-1:STATE_W-1]))
            sat_sum = sum[STATE_W-1:0];
        else if (sum[SUM_W-1])
            sat_sum = {1'b1, {(STATE_W-1){1'b0}}};
        else
            sat_sum = {1'b0, {(STATE_W-1){1'b1}}};
    end

    // Output round and saturate
    assign acc_rnd = acc_reg + ACC_W'(65536);
    assign out_rnd = acc_rnd[ACC_W-1:17];

    always_comb
    begin
        if ((&out_rnd[OUT_RND_W-1:SAMPLE_W-1]) || !(|out_rnd[OUT_RND_W-1:SAMPLE_W-1]))
            sat_out = out_rnd[SAMPLE_W-1:0];
        else if (out_rnd[OUT_RND_W-1])
            sat_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            sat_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end

    always_comb
    begin
        for (int j = 0; j < STAGES; j++)
        begin
            low_wr[j*STATE_W +: STATE_W]  = st_reg[2*j];
            high_wr[j*STATE_W +: STATE_W] = st_reg[2*j+1];
        end
    end

    assign hist_wr = {hist_row[2*SAMPLE_W-1:0], sample_reg};

    // Control, registered outputs and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            pass_reg       <= 1'b0;
            idx_reg        <= '0;
            row_valid_reg  <= 1'b0;
            chan_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            low_coef_reg   <= LOW_COEF_RESET;
            high_coef_reg  <= HIGH_COEF_RESET;
            low_gain_reg   <= GAIN_RESET;
            mid_gain_reg   <= GAIN_RESET;
            high_gain_reg  <= GAIN_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOW_COEF:  low_coef_reg  <= cfg_data[COEF_W-1:0];
                    REG_HIGH_COEF: high_coef_reg <= cfg_data[COEF_W-1:0];
                    REG_LOW_GAIN:  low_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_MID_GAIN:  mid_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_HIGH_GAIN: high_gain_reg <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != ST_FINISH)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        pass_reg      <= !in_range;
                        idx_reg       <= in_idx;
                        row_valid_reg <= in_range && chan_valid_reg[in_idx];
                        state_reg     <= in_range ? ST_LOAD : ST_FINISH;
                    end
                end
                ST_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == STEP_LAST)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_data_reg.channel_out <= ch_reg;
                        out_data_reg.sample_out  <= pass_reg ? sample_reg : sat_out;
                        if (!pass_reg)
                            chan_valid_reg[idx_reg] <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg     <= in_data.channel_in;
            sample_reg <= in_data.sample_in;
        end

        if (state_reg == ST_LOAD)
        begin
            for (int j = 0; j < STAGES; j++)
            begin
                st_reg[2*j]   <= row_valid_reg ? $signed(low_rd_reg[j*STATE_W +: STATE_W])
                                               : '0;
                st_reg[2*j+1] <= row_valid_reg ? $signed(high_rd_reg[j*STATE_W +: STATE_W])
                                               : '0;
            end
            x_low_reg  <= xs;
            x_high_reg <= xs;
        end

        if (state_reg == ST_RUN)
        begin
            prod_reg <= prod_next;
            if (step_reg <= STEP_LAST_UNIT)
                s_hold_reg <= st_reg[0];
            if (step_reg <= STEP_LOW_GAIN)
            begin
                for (int i = 0; i < UNITS - 1; i++)
                    st_reg[i] <= st_reg[i+1];
                st_reg[UNITS-1] <= sat_sum;
            end
            if (step_reg != 4'd0 && step_reg <= STEP_LOW_GAIN)
            begin
                if (step_reg[0])
                    x_low_reg <= sat_sum;
                else
                    x_high_reg <= sat_sum;
            end
            case (step_reg)
                STEP_MID_GAIN:  acc_reg <= {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                STEP_HIGH_GAIN,
                STEP_LAST:      acc_reg <= acc_reg
                                         + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                default: ;
            endcase
        end
    end

    // Channel state memories
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            low_rd_reg  <= low_mem[in_idx];
            high_rd_reg <= high_mem[in_idx];
            hist_rd_reg <= hist_mem[in_idx];
        end
        if (wb_en)
        begin
            low_mem[idx_reg]  <= low_wr;
            high_mem[idx_reg] <= high_wr;
            hist_mem[idx_reg] <= hist_wr;
        end
    end

endmodule

### tb/three_band_audio_equalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-band audio equalizer testbench
// Streams directed and random audio requests through the equalizer under
// several register settings. Random idling and stalls on both channels, plus
// two long receiver hold-offs. A bit-accurate fixed-point predictor computes
// each equalized sample at acceptance. Every result is checked in order.
// ----------------------------------------------------------------------------
module three_band_audio_equalizer_tb;

    import eq3_pkg::*;

    localparam int NUM_CH          = CHANNELS_DEFAULT;
    localparam int IDLE_PCT        = 16;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int ITEMS_PER_PHASE = 144;
    localparam int NUM_PHASES      = 8;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
    localparam longint OUT_MAX   = 64'sd8388607;
    localparam longint OUT_MIN   = -64'sd8388608;
    localparam longint STATE_MAX = 64'sd2147483647;
    localparam longint STATE_MIN = -64'sd2147483648;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    eq_in_t                in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    eq_out_t               out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    three_band_audio_equalizer #(.CHANNELS(NUM_CH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    eq_in_t  pending_samples[$];
    eq_out_t expected_outputs[$];

    longint low_coef_m, high_coef_m, low_gain_m, mid_gain_m, high_gain_m;
    logic signed [STATE_W-1:0]  low_pole  [NUM_CH][STAGES];
    logic signed [STATE_W-1:0]  high_pole [NUM_CH][STAGES];
    logic signed [SAMPLE_W-1:0] history   [NUM_CH][HIST];

    int mismatch_count = 0;
    bit quiet          = 1'b0;
    int stall_ticket   = 0;
    int ticket_seen    = 0;
    int hold_left      = 0;
    int unsigned last_ch = 0;

    function automatic longint round_shr(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint run_poles(input bit high_side, input int ch, input longint x,
                                         input longint coef);
        longint s;
        for (int i = 0; i < STAGES; i++)
        begin
            s = high_side ? longint'(high_pole[ch][i]) : longint'(low_pole[ch][i]);
            s = clamp(s + round_shr((x - s) * coef, 16), STATE_MIN, STATE_MAX);
            if (high_side)
                high_pole[ch][i] = s[STATE_W-1:0];
            else
                low_pole[ch][i] = s[STATE_W-1:0];
            x = s;
        end
        return x;
    endfunction

    task automatic equalize_sample(input eq_in_t req);
        eq_out_t res;
        longint  x, xs, lo, hi_lp, dly, hb, mb, acc;
        int      ch;
        ch = int'(req.channel_in);
        x = longint'(req.sample_in);
        res.channel_out = req.channel_in;
        if (ch >= NUM_CH)
            res.sample_out = req.sample_in;
        else
        begin
            xs = x * 32;
            lo = run_poles(1'b0, ch, xs, low_coef_m);
            hi_lp = run_poles(1'b1, ch, xs, high_coef_m);
            dly = longint'(history[ch][2]);
            dly = dly * 32;
            hb = dly - hi_lp;
            mb = dly - (hb + lo);
            acc = lo * low_gain_m + mb * mid_gain_m + hb * high_gain_m;
            acc = clamp(round_shr(acc, 17), OUT_MIN, OUT_MAX);
            history[ch][2] = history[ch][1];
            history[ch][1] = history[ch][0];
            history[ch][0] = req.sample_in;
            res.sample_out = acc[SAMPLE_W-1:0];
        end
        expected_outputs.push_back(res);
    endtask

    // Driver: hold each request until accepted, idle at random between requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                equalize_sample(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_samples.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        eq_out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual ch=%0d sample=%0d",
                             $time, out_data.channel_out, out_data.sample_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (want.channel_out !== out_data.channel_out)
                    begin
                        $display("%0t channel mismatch: expected %0d actual %0d",
                                 $time, want.channel_out, out_data.channel_out);
                        mismatch_count++;
                    end
                    if (want.sample_out !== out_data.sample_out)
                    begin
                        $display("%0t sample mismatch (ch %0d): expected %0d actual %0d",
                                 $time, want.channel_out, want.sample_out,
                                 out_data.sample_out);
                        mismatch_count++;
                    end
                end
            end
            if (stall_ticket != ticket_seen)
            begin
                ticket_seen <= stall_ticket;
                hold_left   <= LONG_HOLD;
                out_ready   <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_LOW_COEF:  low_coef_m  = longint'(val[COEF_W-1:0]);
            REG_HIGH_COEF: high_coef_m = longint'(val[COEF_W-1:0]);
            REG_LOW_GAIN:  low_gain_m  = longint'(val[GAIN_W-1:0]);
            REG_MID_GAIN:  mid_gain_m  = longint'(val[GAIN_W-1:0]);
            REG_HIGH_GAIN: high_gain_m = longint'(val[GAIN_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained;
        while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input int ch, input logic signed [SAMPLE_W-1:0] val);
        eq_in_t req;
        req.channel_in = ch[CH_FIELD_W-1:0];
        req.sample_in  = val;
        pending_samples.push_back(req);
    endtask

    function automatic eq_in_t random_sample();
        eq_in_t req;
        int     kind;
        if ($urandom_range(1) == 0)
            last_ch = $urandom_range(2 ** CH_FIELD_W - 1);
        req.channel_in = last_ch[CH_FIELD_W-1:0];
        kind = $urandom_range(9);
        case (kind)
            5, 6:    req.sample_in = $signed(24'($urandom_range(511))) - 24'sd256;
            7:       req.sample_in = SAMPLE_MAX;
            8:       req.sample_in = SAMPLE_MIN;
            9:       req.sample_in = SAMPLE_MAX - 24'($urandom_range(1023));
            default: req.sample_in = SAMPLE_W'($urandom);
        endcase
        return req;
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] lc, hc, lg, mg, hg;
        logic [CFG_IDX_W-1:0]  spare;
        low_coef_m  = longint'(LOW_COEF_RESET);
        high_coef_m = longint'(HIGH_COEF_RESET);
        low_gain_m  = longint'(GAIN_RESET);
        mid_gain_m  = longint'(GAIN_RESET);
        high_gain_m = longint'(GAIN_RESET);
        foreach (low_pole[c, s])
        begin
            low_pole[c][s]  = '0;
            high_pole[c][s] = '0;
        end
        foreach (history[c, s])
            history[c][s] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Steps, impulses and alternating extremes under reset settings.
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            queue_sample(0, SAMPLE_MAX);
        for (int i = 0; i < 3; i++)
            queue_sample(0, SAMPLE_MIN);
        queue_sample(0, 24'sd0);
        queue_sample(0, 24'sd1);
        queue_sample(0, -24'sd1);
        queue_sample(7, 24'sd1);
        for (int i = 0; i < 3; i++)
            queue_sample(7, 24'sd0);
        for (int i = 0; i < 2; i++)
        begin
            queue_sample(3, SAMPLE_MIN);
            queue_sample(3, SAMPLE_MAX);
        end
        queue_sample(5, 24'h555555);
        queue_sample(5, 24'hAAAAAA);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase != 0)
            begin
                case (phase)
                    1:
                    begin
                        lc = '1;
                        hc = '1;
                        lg = 17'h0FFFF;
                        mg = 17'h0FFFF;
                        hg = 17'h0FFFF;
                    end
                    2:
                    begin
                        lc = '0;
                        hc = '0;
                        lg = '0;
                        mg = '0;
                        hg = '0;
                    end
                    3:
                    begin
                        lc = 17'h10000;
                        hc = 17'h10000;
                        lg = 17'h10000 | GAIN_RESET;
                        mg = 17'h10000 | GAIN_RESET;
                        hg = 17'h10000 | GAIN_RESET;
                    end
                    default:
                    begin
                        lc = CFG_DATA_W'($urandom);
                        hc = CFG_DATA_W'($urandom);
                        lg = CFG_DATA_W'($urandom);
                        mg = CFG_DATA_W'($urandom);
                        hg = CFG_DATA_W'($urandom);
                    end
                endcase
                write_reg(REG_LOW_COEF, lc);
                write_reg(REG_HIGH_COEF, hc);
                write_reg(REG_LOW_GAIN, lg);
                write_reg(REG_MID_GAIN, mg);
                write_reg(REG_HIGH_GAIN, hg);
                if (phase == 3)
                begin
                    for (int k = 1; k <= 3; k++)
                    begin
                        spare = REG_HIGH_GAIN + k[CFG_IDX_W-1:0];
                        write_reg(spare, CFG_DATA_W'($urandom));
                    end
                end
            end
            quiet = (phase == 5);
            @(negedge clk);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                pending_samples.push_back(random_sample());
            if (phase == 0 || phase == 6)
                stall_ticket = stall_ticket + 1;
            wait_drained();
        end

        if (mismatch_count == 0 && expected_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
